>>> rtl/hpt_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath bundles for the hashed
// page table lookup and allocate unit; no dependencies
package hpt_pkg;

   // table geometry
   localparam int TABLE_ENTRIES_DEF = 8192;
   localparam int SLOT_BITS         = 3;          // eight slots per group
   localparam int GROUP_BITS        = 19;         // group number, offset bits 24..6
   localparam int INDEX_BITS        = 22;
   localparam int SEG_SHIFT         = 28;
   localparam logic [15:0] MIN_HASH_MASK = 16'hFFC0;

   // field widths
   localparam int KIND_BITS   = 2;
   localparam int SPACE_BITS  = 20;
   localparam int WORD_BITS   = 32;
   localparam int STATUS_BITS = 3;
   localparam int MASK_BITS   = 9;
   localparam int VSID_BITS   = 24;

   // configuration port
   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_TABLE_BASE   = 2'd0;
   localparam logic [1:0] REG_TABLE_MASK   = 2'd1;
   localparam logic [1:0] REG_EMPTY_MARKER = 2'd2;

   // request kinds
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ALLOC  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_WRITE  = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_HIT_PRI   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_HIT_SEC   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_ALLOC_PRI = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_ALLOC_SEC = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_MISS      = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_WRITTEN   = 3'd6;

   // controller to datapath
   typedef struct packed {
      logic                   clear_en;   // write zero at clear pointer
      logic                   load;       // capture a new transaction
      logic                   rd_en;      // read one slot of the scan
      logic [SLOT_BITS:0]     rd_slot;    // msb selects secondary group
      logic                   finish;     // load result, do pending write
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic req_is_write;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/hpt_req_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready handshake with lookup, allocate and write fields
// depends on hpt_pkg
interface hpt_req_if;
   logic                                valid;
   logic                                ready;
   logic [hpt_pkg::KIND_BITS-1:0]       kind;
   logic [hpt_pkg::SPACE_BITS-1:0]      space_id;
   logic [hpt_pkg::WORD_BITS-1:0]       virt_addr;
   logic [hpt_pkg::INDEX_BITS-1:0]      load_index;
   logic [hpt_pkg::WORD_BITS-1:0]       load_word;

   modport source (output valid, kind, space_id, virt_addr, load_index, load_word,
                   input ready);
   modport sink (input valid, kind, space_id, virt_addr, load_index, load_word,
                 output ready);
endinterface

>>> rtl/hpt_rsp_if.sv
`timescale 1ns / 1ps
// response channel: valid/ready handshake with status and slot fields
// depends on hpt_pkg
interface hpt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [hpt_pkg::STATUS_BITS-1:0]     status;
   logic [hpt_pkg::INDEX_BITS-1:0]      slot_index;
   logic [hpt_pkg::WORD_BITS-1:0]       slot_address;
   logic [hpt_pkg::WORD_BITS-1:0]       slot_word;

   modport source (output valid, status, slot_index, slot_address, slot_word,
                   input ready);
   modport sink (input valid, status, slot_index, slot_address, slot_word,
                 output ready);
endinterface

>>> rtl/hpt_csr.sv
`timescale 1ns / 1ps
// apb-style configuration registers: table base, hash mask, empty marker
// depends on hpt_pkg
module hpt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hpt_pkg::CSR_AW-1:0]         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output logic [hpt_pkg::WORD_BITS-1:0]      table_base,
   output logic [hpt_pkg::MASK_BITS-1:0]      table_mask,
   output logic [hpt_pkg::WORD_BITS-1:0]      empty_marker
);
   logic [hpt_pkg::WORD_BITS-1:0] base_ff, base_in;
   logic [hpt_pkg::MASK_BITS-1:0] mask_ff, mask_in;
   logic [hpt_pkg::WORD_BITS-1:0] empty_ff, empty_in;
   logic                          wr_en;
   logic [1:0]                    reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      base_in  = base_ff;
      mask_in  = mask_ff;
      empty_in = empty_ff;
      prdata   = '0;
      unique case (reg_sel)
         hpt_pkg::REG_TABLE_BASE: begin
            prdata = base_ff;
            if (wr_en) base_in = pwdata;
         end
         hpt_pkg::REG_TABLE_MASK: begin
            prdata = {{(32 - hpt_pkg::MASK_BITS){1'b0}}, mask_ff};
            if (wr_en) mask_in = pwdata[hpt_pkg::MASK_BITS-1:0];
         end
         hpt_pkg::REG_EMPTY_MARKER: begin
            prdata = empty_ff;
            if (wr_en) empty_in = pwdata;
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         mask_ff  <= '0;
         empty_ff <= '0;
      end else begin
         base_ff  <= base_in;
         mask_ff  <= mask_in;
         empty_ff <= empty_in;
      end
   end

   assign table_base   = base_ff;
   assign table_mask   = mask_ff;
   assign empty_marker = empty_ff;
endmodule

>>> rtl/hpt_ctrl.sv
`timescale 1ns / 1ps
// controller: clear sweep after reset, sixteen-slot scan sequencing, result hand-off
// depends on hpt_pkg
module hpt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hpt_pkg::sts_type    sts,
   output hpt_pkg::cmd_type    cmd
);
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [hpt_pkg::SLOT_BITS:0]  scan_ff, scan_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      cmd          = '0;
      cmd.rd_slot  = scan_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               scan_in  = '0;
               state_in = sts.req_is_write ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == '1) state_in = S_DRAIN;
         end
         // last read word is checked here
         S_DRAIN: state_in = S_FINISH;
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end
endmodule

>>> rtl/hpt_dp.sv
`timescale 1ns / 1ps
// datapath: hash and match word, entry store, group scan flags, result register
// depends on hpt_pkg
module hpt_dp #(
   parameter int TABLE_ENTRIES = hpt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hpt_pkg::cmd_type                     cmd,
   output hpt_pkg::sts_type                     sts,
   input  logic [hpt_pkg::WORD_BITS-1:0]        table_base,
   input  logic [hpt_pkg::MASK_BITS-1:0]        table_mask,
   input  logic [hpt_pkg::WORD_BITS-1:0]        empty_marker,
   input  logic [hpt_pkg::KIND_BITS-1:0]        req_kind,
   input  logic [hpt_pkg::SPACE_BITS-1:0]       req_space_id,
   input  logic [hpt_pkg::WORD_BITS-1:0]        req_virt_addr,
   input  logic [hpt_pkg::INDEX_BITS-1:0]       req_load_index,
   input  logic [hpt_pkg::WORD_BITS-1:0]        req_load_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hpt_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [hpt_pkg::INDEX_BITS-1:0]       rsp_slot_index,
   output logic [hpt_pkg::WORD_BITS-1:0]        rsp_slot_address,
   output logic [hpt_pkg::WORD_BITS-1:0]        rsp_slot_word
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int SB = hpt_pkg::SLOT_BITS;
   localparam int GB = hpt_pkg::GROUP_BITS;
   localparam int IB = hpt_pkg::INDEX_BITS;
   localparam int WB = hpt_pkg::WORD_BITS;

   // entry store
   logic [WB-1:0] mem [TABLE_ENTRIES];
   logic [WB-1:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [WB-1:0] mem_wdata;
   logic [AW-1:0] clr_ff;

   // captured transaction
   logic [hpt_pkg::KIND_BITS-1:0] kind_ff;
   logic [IB-1:0]                 lidx_ff;
   logic [WB-1:0]                 lword_ff;
   logic [WB-1:0]                 want_ff [2];
   logic [GB-1:0]                 grp_ff [2];

   // scan bookkeeping
   logic          chk_vld_ff;
   logic [SB:0]   chk_slot_ff;
   logic [1:0]    hit_ff, hit_in;
   logic [1:0]    emp_ff, emp_in;
   logic [SB-1:0] hit_slot_ff [2];
   logic [SB-1:0] hit_slot_in [2];
   logic [SB-1:0] emp_slot_ff [2];
   logic [SB-1:0] emp_slot_in [2];

   // hash of the incoming transaction
   logic [hpt_pkg::VSID_BITS-1:0] vsid;
   logic [15:0]                   pidx;
   logic [5:0]                    api;
   logic [GB-1:0]                 gmask;
   logic [GB-1:0]                 grp0;
   logic [WB-1:0]                 want0;

   // result
   logic [hpt_pkg::STATUS_BITS-1:0] res_status;
   logic [IB-1:0]                   res_idx;
   logic [WB-1:0]                   res_word;
   logic                            res_we;
   logic                            res_found;
   logic [WB-1:0]                   res_addr;
   logic [IB-1:0]                   scan_idx;

   logic                            rsp_valid_ff;
   logic [hpt_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [IB-1:0]                   rsp_idx_ff;
   logic [WB-1:0]                   rsp_addr_ff;
   logic [WB-1:0]                   rsp_word_ff;

   assign vsid  = {req_space_id, req_virt_addr[WB-1:hpt_pkg::SEG_SHIFT]};
   assign pidx  = req_virt_addr[27:12];
   assign api   = req_virt_addr[27:22];
   assign gmask = {table_mask, hpt_pkg::MIN_HASH_MASK[15:6]};
   assign grp0  = (vsid[GB-1:0] ^ {{(GB - 16){1'b0}}, pidx}) & gmask;
   assign want0 = {1'b1, vsid, 1'b0, api};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= req_kind;
         lidx_ff    <= req_load_index;
         lword_ff   <= req_load_word;
         want_ff[0] <= want0;
         want_ff[1] <= want0 | 32'h0000_0040;
         grp_ff[0]  <= grp0;
         grp_ff[1]  <= grp0 ^ gmask;
      end
   end

   // slot index of the scan read; group first slot is the offset over eight
   assign scan_idx = {grp_ff[cmd.rd_slot[SB]], cmd.rd_slot[SB-1:0]};

   always_comb begin
      res_status = hpt_pkg::ST_MISS;
      res_idx    = '0;
      res_word   = '0;
      res_we     = 1'b0;
      res_found  = 1'b0;
      if (kind_ff == hpt_pkg::KIND_WRITE) begin
         res_status = hpt_pkg::ST_WRITTEN;
         res_idx    = lidx_ff;
         res_word   = lword_ff;
         res_we     = 1'b1;
         res_found  = 1'b1;
      end else if (hit_ff[0]) begin
         res_status = hpt_pkg::ST_HIT_PRI;
         res_idx    = {grp_ff[0], hit_slot_ff[0]};
         res_word   = want_ff[0];
         res_found  = 1'b1;
      end else if (hit_ff[1]) begin
         res_status = hpt_pkg::ST_HIT_SEC;
         res_idx    = {grp_ff[1], hit_slot_ff[1]};
         res_word   = want_ff[1];
         res_found  = 1'b1;
      end else if (kind_ff == hpt_pkg::KIND_ALLOC) begin
         res_status = hpt_pkg::ST_OVERFLOW;
         if (emp_ff[0]) begin
            res_status = hpt_pkg::ST_ALLOC_PRI;
            res_idx    = {grp_ff[0], emp_slot_ff[0]};
            res_word   = {1'b0, want_ff[0][WB-2:0]};
            res_we     = 1'b1;
            res_found  = 1'b1;
         end else if (emp_ff[1]) begin
            res_status = hpt_pkg::ST_ALLOC_SEC;
            res_idx    = {grp_ff[1], emp_slot_ff[1]};
            res_word   = {1'b0, want_ff[1][WB-2:0]};
            res_we     = 1'b1;
            res_found  = 1'b1;
         end
      end
   end

   assign res_addr = res_found ? table_base + {{(WB - IB - SB){1'b0}}, res_idx, {SB{1'b0}}}
                               : '0;

   // single port: clear sweep, scan reads and the final write never overlap
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = res_word;
      mem_addr  = scan_idx[AW-1:0];
      if (cmd.clear_en) begin
         mem_we    = 1'b1;
         mem_wdata = '0;
         mem_addr  = clr_ff;
      end else if (cmd.finish) begin
         mem_we   = res_we;
         mem_addr = res_idx[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_en) clr_ff <= clr_ff + 1'b1;
   end

   // first matching and first empty slot of each group
   always_comb begin
      hit_in      = hit_ff;
      emp_in      = emp_ff;
      hit_slot_in = hit_slot_ff;
      emp_slot_in = emp_slot_ff;
      if (cmd.load) begin
         hit_in = '0;
         emp_in = '0;
      end else if (chk_vld_ff) begin
         for (int g = 0; g < 2; g++) begin
            if (chk_slot_ff[SB] == g[0]) begin
               if (!hit_ff[g] && rd_data_ff == want_ff[g]) begin
                  hit_in[g]      = 1'b1;
                  hit_slot_in[g] = chk_slot_ff[SB-1:0];
               end
               if (!emp_ff[g] && rd_data_ff == empty_marker) begin
                  emp_in[g]      = 1'b1;
                  emp_slot_in[g] = chk_slot_ff[SB-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
         hit_ff     <= '0;
         emp_ff     <= '0;
      end else begin
         chk_vld_ff <= cmd.rd_en;
         hit_ff     <= hit_in;
         emp_ff     <= emp_in;
      end
      chk_slot_ff <= cmd.rd_slot;
      hit_slot_ff <= hit_slot_in;
      emp_slot_ff <= emp_slot_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.finish) begin
         rsp_status_ff <= res_status;
         rsp_idx_ff    <= res_idx;
         rsp_addr_ff   <= res_addr;
         rsp_word_ff   <= res_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_index   = rsp_idx_ff;
   assign rsp_slot_address = rsp_addr_ff;
   assign rsp_slot_word    = rsp_word_ff;

   assign sts.clear_last   = (clr_ff == '1);
   assign sts.req_is_write = (req_kind == hpt_pkg::KIND_WRITE);
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;
endmodule

>>> rtl/hashed_page_table_lookup_alloc_unit.sv
`timescale 1ns / 1ps
// top level of the hashed page table lookup and allocate unit
// depends on hpt_pkg, hpt_req_if, hpt_rsp_if, hpt_csr, hpt_ctrl, hpt_dp

// Holds TABLE_ENTRIES first page-table words (a power of two) in one single-port
// memory. After reset a clearing pass writes zero to every entry, one per cycle,
// and no transaction is taken until it ends; configuration writes are taken
// throughout. A write transaction goes to the finish state on acceptance and its
// result is registered once the output register is free. A lookup or allocate
// reads the eight slots of the primary and of the secondary group through the
// one memory port, one slot per cycle, noting the first match and first empty
// slot of each group, checks the last read in the drain state, then resolves and
// does any allocate write in the finish state. One transaction is worked on at a
// time; a finished result waits in the output register as the next is accepted.
module hashed_page_table_lookup_alloc_unit #(
   parameter int TABLE_ENTRIES = hpt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   hpt_req_if.sink                     req_ch,
   hpt_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [hpt_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   hpt_pkg::cmd_type               cmd;
   hpt_pkg::sts_type               sts;
   logic [hpt_pkg::WORD_BITS-1:0]  table_base;
   logic [hpt_pkg::MASK_BITS-1:0]  table_mask;
   logic [hpt_pkg::WORD_BITS-1:0]  empty_marker;

   hpt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .table_base   (table_base),
      .table_mask   (table_mask),
      .empty_marker (empty_marker)
   );

   hpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hpt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .table_base       (table_base),
      .table_mask       (table_mask),
      .empty_marker     (empty_marker),
      .req_kind         (req_ch.kind),
      .req_space_id     (req_ch.space_id),
      .req_virt_addr    (req_ch.virt_addr),
      .req_load_index   (req_ch.load_index),
      .req_load_word    (req_ch.load_word),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_status       (rsp_ch.status),
      .rsp_slot_index   (rsp_ch.slot_index),
      .rsp_slot_address (rsp_ch.slot_address),
      .rsp_slot_word    (rsp_ch.slot_word)
   );
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the hashed page table lookup and allocate unit:
// predicts every result from a shadow table and compares each field in order
// depends on hpt_pkg, hpt_req_if, hpt_rsp_if and the unit's rtl
module testbench;

   localparam int TABLE_ENTRIES = hpt_pkg::TABLE_ENTRIES_DEF;
   localparam logic [hpt_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;   // decoded as a lookup
   localparam logic [31:0] VALID_BIT = 32'h8000_0000;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int PHASE_ITEMS = 240;
   localparam int POOL_KEYS = 8;

   localparam logic [19:0] A_SID = 20'h00001;
   localparam logic [31:0] A_VA  = 32'h1234_5000;
   localparam logic [19:0] B_SID = 20'h00ABC;
   localparam logic [31:0] B_VA  = 32'h0040_0000;
   localparam logic [19:0] C_SID = 20'hF0F0F;
   localparam logic [31:0] C_VA  = 32'hDEAD_B000;

   typedef struct packed {
      logic [hpt_pkg::STATUS_BITS-1:0] status;
      logic [hpt_pkg::INDEX_BITS-1:0]  slot_index;
      logic [hpt_pkg::WORD_BITS-1:0]   slot_address;
      logic [hpt_pkg::WORD_BITS-1:0]   slot_word;
   } slot_result_type;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [hpt_pkg::CSR_AW-1:0] paddr;
   logic [31:0] pwdata, prdata;

   hpt_req_if req_if ();
   hpt_rsp_if rsp_if ();

   hashed_page_table_lookup_alloc_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow copy of the table and registers
   bit [31:0] page_table_words [TABLE_ENTRIES];
   bit [31:0] cfg_table_base;
   bit [8:0]  cfg_table_mask;
   bit [31:0] cfg_empty_marker;

   slot_result_type pending_slot_results [$];
   int failure_count = 0;
   int results_checked = 0;
   int items_sent = 0;
   int idle_cycles = 0;
   int next_gap = 0;
   bit offering = 1'b0;
   bit no_idle = 1'b0;
   bit hold_pending = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(12, 60);
   endfunction

   function automatic logic [31:0] hash_offset(input logic [19:0] sid, input logic [31:0] va,
                                               input bit secondary);
      logic [23:0] vsid;
      logic [31:0] hmask;
      logic [31:0] offs;
      vsid = {sid, va[31:28]};
      hmask = {7'd0, cfg_table_mask, hpt_pkg::MIN_HASH_MASK};
      offs = {2'b00, vsid ^ {8'd0, va[27:12]}, 6'd0} & hmask;
      return secondary ? (offs ^ hmask) : offs;
   endfunction

   function automatic logic [31:0] match_word(input logic [19:0] sid, input logic [31:0] va,
                                              input bit secondary);
      return {1'b1, sid, va[31:28], secondary, va[27:22]};
   endfunction

   function automatic int scan_group(input logic [31:0] first, input logic [31:0] word);
      for (int s = 0; s < 8; s++)
         if (page_table_words[(first + s) % TABLE_ENTRIES] == word) return s;
      return -1;
   endfunction

   function automatic slot_result_type predict_slot_result(input logic [1:0] kind,
                                                           input logic [19:0] sid,
                                                           input logic [31:0] va,
                                                           input logic [21:0] lidx,
                                                           input logic [31:0] lword);
      slot_result_type r;
      logic [31:0] offs;
      int found;
      int grp;
      r = '0;
      r.status = hpt_pkg::ST_MISS;
      found = -1;
      grp = 0;
      if (kind == hpt_pkg::KIND_WRITE) begin
         page_table_words[lidx % TABLE_ENTRIES] = lword;
         r.status = hpt_pkg::ST_WRITTEN;
         r.slot_index = lidx;
         r.slot_address = cfg_table_base + {7'd0, lidx, 3'd0};
         r.slot_word = lword;
         return r;
      end
      for (int g = 0; g < 2 && found < 0; g++) begin
         found = scan_group(hash_offset(sid, va, g != 0) >> 3, match_word(sid, va, g != 0));
         grp = g;
      end
      if (found >= 0) begin
         r.status = (grp == 0) ? hpt_pkg::ST_HIT_PRI : hpt_pkg::ST_HIT_SEC;
      end else if (kind == hpt_pkg::KIND_ALLOC) begin
         r.status = hpt_pkg::ST_OVERFLOW;
         for (int g = 0; g < 2 && found < 0; g++) begin
            found = scan_group(hash_offset(sid, va, g != 0) >> 3, cfg_empty_marker);
            grp = g;
         end
         if (found >= 0) begin
            r.status = (grp == 0) ? hpt_pkg::ST_ALLOC_PRI : hpt_pkg::ST_ALLOC_SEC;
            offs = hash_offset(sid, va, grp != 0);
            page_table_words[((offs >> 3) + found) % TABLE_ENTRIES] =
               match_word(sid, va, grp != 0) & ~VALID_BIT;
         end
      end
      if (found >= 0) begin
         offs = hash_offset(sid, va, grp != 0);
         r.slot_index = 22'((offs >> 3) + found);
         r.slot_address = cfg_table_base + offs + 32'(found << 3);
         r.slot_word = page_table_words[r.slot_index % TABLE_ENTRIES];
      end
      return r;
   endfunction

   function automatic logic [1:0] pick_lookup_kind();
      return ($urandom_range(0, 4) == 0) ? KIND_UNUSED : hpt_pkg::KIND_LOOKUP;
   endfunction

   task automatic log_failure(input string msg);
      failure_count++;
      if (failure_count <= 10) $display("%s", msg);
   endtask

   task automatic send_request(input logic [1:0] kind, input logic [19:0] sid,
                               input logic [31:0] va, input logic [21:0] lidx,
                               input logic [31:0] lword, output slot_result_type predicted);
      repeat (next_gap) @(posedge clock);
      req_if.valid      <= 1'b1;
      req_if.kind       <= kind;
      req_if.space_id   <= sid;
      req_if.virt_addr  <= va;
      req_if.load_index <= lidx;
      req_if.load_word  <= lword;
      offering = 1'b1;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predicted = predict_slot_result(kind, sid, va, lidx, lword);
      pending_slot_results.push_back(predicted);
      items_sent++;
      // keep valid up when the next transaction follows at once
      next_gap = random_gap();
      if (next_gap > 0) begin
         req_if.valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic stop_offering();
      if (offering) begin
         req_if.valid <= 1'b0;
         offering = 1'b0;
         next_gap = 1;
      end
   endtask

   task automatic wait_until_drained();
      stop_offering();
      while (pending_slot_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] sel, input logic [31:0] value);
      wait_until_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (sel)
         hpt_pkg::REG_TABLE_BASE:   cfg_table_base = value;
         hpt_pkg::REG_TABLE_MASK:   cfg_table_mask = value[8:0];
         hpt_pkg::REG_EMPTY_MARKER: cfg_empty_marker = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_table(input logic [31:0] base, input logic [8:0] mask,
                            input logic [31:0] marker);
      write_register(hpt_pkg::REG_TABLE_BASE, base);
      write_register(hpt_pkg::REG_TABLE_MASK, {23'd0, mask});
      write_register(hpt_pkg::REG_EMPTY_MARKER, marker);
   endtask

   // registers are taken while the table is still being cleared
   task automatic test_registers_during_clear();
      set_table(32'h0001_0000, 9'h000, 32'h0000_0000);
   endtask

   task automatic test_directed_search();
      slot_result_type r;
      logic [31:0] first;
      send_request(hpt_pkg::KIND_LOOKUP, A_SID, A_VA, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_ALLOC, A_SID, A_VA, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_LOOKUP, A_SID, A_VA, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_WRITE, A_SID, A_VA, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_WRITE, 20'd0, 32'd0,
                   22'(hash_offset(A_SID, A_VA, 1'b0) >> 3),
                   match_word(A_SID, A_VA, 1'b0), r);
      send_request(hpt_pkg::KIND_LOOKUP, A_SID, A_VA, 22'd0, 32'd0, r);
      send_request(KIND_UNUSED, A_SID, A_VA, 22'd0, 32'd0, r);
      // fill the primary group so the claim lands in the secondary one
      first = hash_offset(B_SID, B_VA, 1'b0) >> 3;
      for (int s = 0; s < 8; s++)
         send_request(hpt_pkg::KIND_WRITE, 20'd0, 32'd0, 22'(first + s),
                      32'h0BAD_0000 | 32'(s), r);
      send_request(hpt_pkg::KIND_ALLOC, B_SID, B_VA, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_WRITE, 20'd0, 32'd0, r.slot_index,
                   r.slot_word | VALID_BIT, r);
      send_request(hpt_pkg::KIND_LOOKUP, B_SID, B_VA, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_LOOKUP, 20'hFFFFF, 32'hFFFF_FFFF, 22'h3FFFFF,
                   32'hFFFF_FFFF, r);
      send_request(hpt_pkg::KIND_ALLOC, 20'd0, 32'd0, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_WRITE, 20'hFFFFF, 32'hFFFF_FFFF, 22'h3FFFFF,
                   32'hFFFF_FFFF, r);
      send_request(hpt_pkg::KIND_WRITE, 20'd0, 32'd0, 22'd0, 32'd0, r);
   endtask

   // no free slot anywhere, then one free slot in a secondary group past the store size
   task automatic test_overflow_and_wrap();
      slot_result_type r;
      set_table(32'hFFFF_FFF8, 9'h1FF, 32'hFFFF_FFFF);
      send_request(hpt_pkg::KIND_ALLOC, C_SID, C_VA, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_WRITE, 20'd0, 32'd0,
                   22'((hash_offset(C_SID, C_VA, 1'b1) >> 3) + 3), 32'hFFFF_FFFF, r);
      send_request(hpt_pkg::KIND_ALLOC, C_SID, C_VA, 22'd0, 32'd0, r);
      send_request(hpt_pkg::KIND_LOOKUP, C_SID, C_VA, 22'd0, 32'd0, r);
   endtask

   task automatic test_output_backpressure();
      slot_result_type r;
      no_idle = 1'b1;
      hold_pending = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 2)
            send_request(hpt_pkg::KIND_WRITE, 20'($urandom), $urandom, 22'($urandom),
                         $urandom, r);
         else
            send_request(hpt_pkg::KIND_ALLOC, 20'($urandom), $urandom, 22'($urandom),
                         $urandom, r);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_phases();
      slot_result_type r;
      logic [19:0] pool_sid [POOL_KEYS];
      logic [31:0] pool_va [POOL_KEYS];
      logic [31:0] first;
      int start;
      int k;
      int pick;
      int n;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_table(32'h0000_0000, 9'h000, 32'h0000_0000);
            1: set_table(32'hFFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF);
            2: set_table($urandom & 32'hFE00_0000, 9'($urandom_range(1, 510)), $urandom);
            3: set_table($urandom | 32'h4, 9'h1FF, 32'h0000_0000);
            4: set_table(32'h8000_0000, 9'h000, $urandom);
            default: set_table($urandom, 9'($urandom_range(0, 511)), 32'h0000_0000);
         endcase
         no_idle = (phase == 3);
         for (int i = 0; i < POOL_KEYS; i++) begin
            pool_sid[i] = 20'($urandom);
            pool_va[i] = $urandom;
         end
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            k = $urandom_range(0, POOL_KEYS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               // claim a slot, mark it valid, then find it again
               send_request(hpt_pkg::KIND_ALLOC, pool_sid[k], pool_va[k], 22'($urandom),
                            $urandom, r);
               if (r.status == hpt_pkg::ST_ALLOC_PRI || r.status == hpt_pkg::ST_ALLOC_SEC)
               begin
                  send_request(hpt_pkg::KIND_WRITE, 20'($urandom), $urandom, r.slot_index,
                               r.slot_word | VALID_BIT, r);
                  send_request(pick_lookup_kind(), pool_sid[k], pool_va[k],
                               22'($urandom), $urandom, r);
               end
            end else if (pick < 45) begin
               // seed slots of one group with the free marker or junk
               first = hash_offset(pool_sid[k], pool_va[k], $urandom_range(0, 1) != 0) >> 3;
               n = $urandom_range(1, 8);
               for (int s = 0; s < n; s++)
                  send_request(hpt_pkg::KIND_WRITE, 20'($urandom), $urandom,
                               22'(first + $urandom_range(0, 7)),
                               ($urandom_range(0, 3) == 0) ? $urandom : cfg_empty_marker, r);
            end else if (pick < 80) begin
               send_request(($urandom_range(0, 1) == 0) ? hpt_pkg::KIND_ALLOC
                                                        : pick_lookup_kind(),
                            pool_sid[k], pool_va[k], 22'($urandom), $urandom, r);
            end else begin
               send_request(2'($urandom_range(0, 3)), 20'($urandom), $urandom,
                            22'($urandom), $urandom, r);
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.kind       <= hpt_pkg::KIND_LOOKUP;
      req_if.space_id   <= '0;
      req_if.virt_addr  <= '0;
      req_if.load_index <= '0;
      req_if.load_word  <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_registers_during_clear();
      test_directed_search();
      test_overflow_and_wrap();
      test_output_backpressure();
      test_random_phases();
      wait_until_drained();
      repeat (40) @(posedge clock);
      if (pending_slot_results.size() != 0)
         log_failure($sformatf("%0d results never arrived", pending_slot_results.size()));
      if (failure_count == 0) begin
         $display("hashed_page_table_lookup_alloc_unit verification clean");
      end else begin
         $display("hashed_page_table_lookup_alloc_unit verification failed");
      end
      $finish;
   end

   // response side: random stalls plus one long hold-off on request
   initial begin : result_receiver
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_pending) begin
            stall = HOLD_CYCLES;
            hold_pending = 1'b0;
         end else begin
            stall = random_gap();
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_slot_results
      slot_result_type got;
      slot_result_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.status = rsp_if.status;
         got.slot_index = rsp_if.slot_index;
         got.slot_address = rsp_if.slot_address;
         got.slot_word = rsp_if.slot_word;
         if (pending_slot_results.size() == 0) begin
            log_failure($sformatf("unexpected transaction: status %0d index %h addr %h word %h",
                                  got.status, got.slot_index, got.slot_address,
                                  got.slot_word));
         end else begin
            want = pending_slot_results.pop_front();
            if (got.status !== want.status || got.slot_index !== want.slot_index ||
                got.slot_address !== want.slot_address || got.slot_word !== want.slot_word)
               log_failure($sformatf(
                  "result %0d: expected status %0d index %h addr %h word %h, got %0d %h %h %h",
                  results_checked, want.status, want.slot_index, want.slot_address,
                  want.slot_word, got.status, got.slot_index, got.slot_address,
                  got.slot_word));
         end
         results_checked++;
      end
   end

   // covers the clearing pass after reset and the long hold-off
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("hashed_page_table_lookup_alloc_unit verification failed");
         $finish;
      end
   end

endmodule
